### rtl/core/fray_pkg.sv
// fray_pkg: shared types, constants and helpers of the fisheye ray direction block
// used by fray_cell, fray_chain and fisheye_ray_direction; no dependencies
`default_nettype none

package fray_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_BITS_DEF    = 16;

  localparam int ANG_W     = 30;
  localparam int ROT_W     = 33;
  localparam int TABLE_LEN = 24;
  localparam int PADDR_W   = 4;

  localparam logic signed [30:0]      INV_GAIN = 31'sd652032874;
  localparam logic signed [ANG_W-1:0] PI_ANG   = 30'sd210828714;
  localparam logic signed [ANG_W-1:0] HALF_PI  = 30'sd105414357;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    30'sd52707179, 30'sd31114864, 30'sd16440240, 30'sd8345322, 30'sd4188855,
    30'sd2096470, 30'sd1048491, 30'sd524277, 30'sd262143, 30'sd131072,
    30'sd65536, 30'sd32768, 30'sd16384, 30'sd8192, 30'sd4096, 30'sd2048,
    30'sd1024, 30'sd512, 30'sd256, 30'sd128, 30'sd64, 30'sd32, 30'sd16, 30'sd8
  };

  typedef enum logic [1:0] {
    REG_ASPECT  = 2'd0,
    REG_INVERSE = 2'd1,
    REG_FIELD   = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] coord_s;
    logic [15:0] coord_t;
  } ray_req_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               outside_circle;
  } ray_res_t;

  // round half up from 30 to 14 fraction bits, saturate to +-1.0
  function automatic logic signed [15:0] to_q14(input logic signed [ROT_W:0] v);
    logic signed [ROT_W:0] r;
    begin
      r = (v + (ROT_W+1)'(32768)) >>> 16;
      if (r > (ROT_W+1)'(16384)) begin
        to_q14 = 16'sd16384;
      end else if (r < -(ROT_W+1)'(16384)) begin
        to_q14 = -16'sd16384;
      end else begin
        to_q14 = r[15:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/fray_cell.sv
// fray_cell: one CORDIC micro-rotation, registered, in vectoring or rotation mode
// depends on fray_pkg
`default_nettype none

module fray_cell import fray_pkg::*; #(
  parameter int W   = ROT_W,
  parameter int SW  = 1,
  parameter int IDX = 0,
  parameter bit VEC = 1'b0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic signed [W-1:0]  a_i,
  input  wire logic signed [W-1:0]  b_i,
  input  wire logic signed [ANG_W-1:0] ang_i,
  input  wire logic [SW-1:0]        side_i,
  output logic                      valid_o,
  output logic signed [W-1:0]       a_o,
  output logic signed [W-1:0]       b_o,
  output logic signed [ANG_W-1:0]   ang_o,
  output logic [SW-1:0]             side_o
);

  logic                    sub;
  logic signed [W-1:0]     da;
  logic signed [W-1:0]     db;
  logic signed [W-1:0]     a_d;
  logic signed [W-1:0]     b_d;
  logic signed [ANG_W-1:0] ang_d;

  assign sub = VEC ? b_i[W-1] : ~ang_i[ANG_W-1];
  assign da  = b_i >>> IDX;
  assign db  = a_i >>> IDX;

  always_comb begin
    if (sub) begin
      a_d   = a_i - da;
      b_d   = b_i + db;
      ang_d = ang_i - ATAN_TAB[IDX];
    end else begin
      a_d   = a_i + da;
      b_d   = b_i - db;
      ang_d = ang_i + ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_o    <= a_d;
    b_o    <= b_d;
    ang_o  <= ang_d;
    side_o <= side_i;
  end

endmodule

`default_nettype wire

### rtl/core/fray_chain.sv
// fray_chain: row of fray_cell stages forming one pipelined CORDIC
// depends on fray_pkg and fray_cell
`default_nettype none

module fray_chain import fray_pkg::*; #(
  parameter int N   = CORDIC_STAGES_DEF,
  parameter int W   = ROT_W,
  parameter int SW  = 1,
  parameter bit VEC = 1'b0
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire logic signed [W-1:0]     a_i,
  input  wire logic signed [W-1:0]     b_i,
  input  wire logic signed [ANG_W-1:0] ang_i,
  input  wire logic [SW-1:0]           side_i,
  output logic                         valid_o,
  output logic signed [W-1:0]          a_o,
  output logic signed [W-1:0]          b_o,
  output logic signed [ANG_W-1:0]      ang_o,
  output logic [SW-1:0]                side_o
);

  logic                    v_s   [N+1];
  logic signed [W-1:0]     a_s   [N+1];
  logic signed [W-1:0]     b_s   [N+1];
  logic signed [ANG_W-1:0] ang_s [N+1];
  logic [SW-1:0]           sd_s  [N+1];

  assign v_s[0]   = valid_i;
  assign a_s[0]   = a_i;
  assign b_s[0]   = b_i;
  assign ang_s[0] = ang_i;
  assign sd_s[0]  = side_i;

  for (genvar g = 0; g < N; g++) begin : g_cell
    fray_cell #(.W(W), .SW(SW), .IDX(g), .VEC(VEC)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v_s[g]),
      .a_i    (a_s[g]),
      .b_i    (b_s[g]),
      .ang_i  (ang_s[g]),
      .side_i (sd_s[g]),
      .valid_o(v_s[g+1]),
      .a_o    (a_s[g+1]),
      .b_o    (b_s[g+1]),
      .ang_o  (ang_s[g+1]),
      .side_o (sd_s[g+1])
    );
  end

  assign valid_o = v_s[N];
  assign a_o     = a_s[N];
  assign b_o     = b_s[N];
  assign ang_o   = ang_s[N];
  assign side_o  = sd_s[N];

endmodule

`default_nettype wire

### rtl/core/fisheye_ray_direction.sv
// fisheye_ray_direction: equidistant fisheye pixel-to-ray pipeline with APB registers
// depends on fray_pkg and fray_chain
//
// usage:
//   pixel channel: drive req_i and pulse start; busy is always low, so a
//   transaction is taken on every cycle that start is high
//   result channel: res_o is valid for one cycle while res_valid_o is high;
//   the receiver cannot stall, results come out in input order
//   throughput: one transaction per cycle, set by three rows of pipelined
//   CORDIC cells (vectoring for radius and azimuth, rotation for the polar
//   angle, rotation by the azimuth) with registered multipliers between
//   registers: APB at byte 0 aspect_ratio, 4 inverse_aspect, 8 field_angle;
//   write them only while no transaction is in flight
//   reset: pipeline empties, registers return to 4096, 4096 and 12868
`default_nettype none

module fisheye_ray_direction import fray_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire ray_req_t           req_i,
  output logic                    res_valid_o,
  output ray_res_t                res_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CB  = COORD_BITS;
  localparam int N   = CORDIC_STAGES;
  localparam int CW  = CB + 2;
  localparam int PW  = CW + 17;
  localparam int VW  = CB + 3;
  localparam int QW  = 2 * VW + 1;
  localparam int EW  = VW + 31;
  localparam int RW  = CB + 1;
  localparam int GW  = RW + 15;
  localparam int TW  = CB + 30;
  localparam int HW  = ROT_W + 31;
  localparam int LAT = 11 + 3 * N;

  localparam logic signed [PW-1:0] TWO_P  = PW'(longint'(1) <<< (CB + 1));
  localparam logic signed [QW-1:0] ONE_SQ = QW'(longint'(1) <<< (2 * CB));
  localparam logic signed [EW-1:0] ONE_E  = EW'(longint'(1) <<< CB);
  localparam logic [TW-1:0]        PI_T   = TW'(PI_ANG);

  // configuration
  logic [15:0] aspect_q, inverse_q;
  logic [14:0] field_q;
  logic        wr_en;
  reg_idx_e    wr_idx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aspect_q  <= 16'd4096;
      inverse_q <= 16'd4096;
      field_q   <= 15'd12868;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_ASPECT:  aspect_q  <= pwdata[15:0];
        REG_INVERSE: inverse_q <= pwdata[15:0];
        REG_FIELD:   field_q   <= pwdata[14:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_ASPECT:  prdata = {16'd0, aspect_q};
      REG_INVERSE: prdata = {16'd0, inverse_q};
      REG_FIELD:   prdata = {17'd0, field_q};
      default:     prdata = 32'd0;
    endcase
  end

  // stage a: center, rescale, aspect multiply
  logic signed [17:0]   cs_w, ct_w;
  logic signed [CW-1:0] cs_c, ct_c;
  logic [15:0]          s_mul, t_mul;
  logic signed [PW-1:0] ps_d, pt_d, ps_q, pt_q;
  logic                 va_q;

  assign cs_w = $signed({1'b0, req_i.coord_s, 1'b0}) - 18'sd65536;
  assign ct_w = $signed({1'b0, req_i.coord_t, 1'b0}) - 18'sd65536;

  if (CB >= 16) begin : g_up
    assign cs_c = CW'(cs_w) <<< (CB - 16);
    assign ct_c = CW'(ct_w) <<< (CB - 16);
  end else begin : g_dn
    assign cs_c = CW'(cs_w >>> (16 - CB));
    assign ct_c = CW'(ct_w >>> (16 - CB));
  end

  assign s_mul = (aspect_q > 16'd4096) ? aspect_q : 16'd4096;
  assign t_mul = (aspect_q < 16'd4096) ? inverse_q : 16'd4096;
  assign ps_d  = PW'(cs_c) * PW'($signed({1'b0, s_mul}));
  assign pt_d  = PW'(ct_c) * PW'($signed({1'b0, t_mul}));

  // stage b: scale down and saturate
  logic signed [PW-1:0] ss, ts;
  logic signed [VW-1:0] cs_d, ct_d, cs_q, ct_q;
  logic                 vb_q;

  assign ss = ps_q >>> 12;
  assign ts = pt_q >>> 12;

  always_comb begin
    if (ss > TWO_P) begin
      cs_d = VW'(TWO_P);
    end else if (ss < -TWO_P) begin
      cs_d = VW'(-TWO_P);
    end else begin
      cs_d = VW'(ss);
    end
    if (ts > TWO_P) begin
      ct_d = VW'(TWO_P);
    end else if (ts < -TWO_P) begin
      ct_d = VW'(-TWO_P);
    end else begin
      ct_d = VW'(ts);
    end
  end

  // stage c: squares
  logic signed [QW-1:0] sqs_q, sqt_q;
  logic signed [VW-1:0] cs2_q, ct2_q;
  logic                 vc_q;

  // stage d: outside test and vector fold
  logic signed [VW-1:0]    va_d, vb_d;
  logic signed [ANG_W-1:0] vang_d;
  logic                    out_d;
  logic signed [VW-1:0]    va1_q, vb1_q;
  logic signed [ANG_W-1:0] vang_q;
  logic                    out_q, vd_q;

  assign out_d = (sqs_q + sqt_q) > ONE_SQ;

  always_comb begin
    if (cs2_q[VW-1]) begin
      va_d   = -cs2_q;
      vb_d   = -ct2_q;
      vang_d = ct2_q[VW-1] ? -PI_ANG : PI_ANG;
    end else begin
      va_d   = cs2_q;
      vb_d   = ct2_q;
      vang_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      va_q <= start && !busy;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ps_q   <= ps_d;
    pt_q   <= pt_d;
    cs_q   <= cs_d;
    ct_q   <= ct_d;
    sqs_q  <= QW'(cs_q) * QW'(cs_q);
    sqt_q  <= QW'(ct_q) * QW'(ct_q);
    cs2_q  <= cs_q;
    ct2_q  <= ct_q;
    va1_q  <= va_d;
    vb1_q  <= vb_d;
    vang_q <= vang_d;
    out_q  <= out_d;
  end

  // vectoring row
  logic                    v1;
  logic signed [VW-1:0]    mag1, rest1;
  logic signed [ANG_W-1:0] bear1;
  logic [0:0]              o1;

  fray_chain #(.N(N), .W(VW), .SW(1), .VEC(1'b1)) u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vd_q),
    .a_i    (va1_q),
    .b_i    (vb1_q),
    .ang_i  (vang_q),
    .side_i (out_q),
    .valid_o(v1),
    .a_o    (mag1),
    .b_o    (rest1),
    .ang_o  (bear1),
    .side_o (o1)
  );

  // stages e to h: radius, polar angle
  logic signed [EW-1:0]    pe_q, re;
  logic [RW-1:0]           rad_d, rad_q;
  logic [GW-1:0]           pg_q;
  logic [TW-1:0]           tt;
  logic signed [ANG_W-1:0] tilt_d, tilt_q;
  logic signed [ANG_W-1:0] be_q, bf_q, bg_q, bh_q;
  logic                    oe_q, of_q, og_q, oh_q;
  logic                    ve_q, vf_q, vg_q, vh_q;

  assign re = pe_q >>> 30;

  always_comb begin
    if (re < 0) begin
      rad_d = '0;
    end else if (re > ONE_E) begin
      rad_d = RW'(ONE_E);
    end else begin
      rad_d = RW'(re);
    end
  end

  if (CB >= 13) begin : g_tr
    assign tt = TW'(pg_q) >> (CB - 13);
  end else begin : g_tl
    assign tt = TW'(pg_q) << (13 - CB);
  end

  assign tilt_d = ((tt > PI_T) ? PI_ANG : ANG_W'(tt)) - HALF_PI;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
    end else begin
      ve_q <= v1;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pe_q   <= EW'(mag1) * EW'(INV_GAIN);
    rad_q  <= rad_d;
    pg_q   <= GW'(rad_q) * GW'(field_q);
    tilt_q <= tilt_d;
    be_q   <= bear1;
    bf_q   <= be_q;
    bg_q   <= bf_q;
    bh_q   <= bg_q;
    oe_q   <= o1[0];
    of_q   <= oe_q;
    og_q   <= of_q;
    oh_q   <= og_q;
  end

  // rotation row for sin and cos of the polar angle
  logic                    v2;
  logic signed [ROT_W-1:0] ca2, sa2;
  logic signed [ANG_W-1:0] res2;
  logic [ANG_W:0]          sd2;

  fray_chain #(.N(N), .W(ROT_W), .SW(ANG_W + 1), .VEC(1'b0)) u_rot1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vh_q),
    .a_i    (ROT_W'(INV_GAIN)),
    .b_i    ('0),
    .ang_i  (tilt_q),
    .side_i ({bh_q, oh_q}),
    .valid_o(v2),
    .a_o    (ca2),
    .b_o    (sa2),
    .ang_o  (res2),
    .side_o (sd2)
  );

  // stages i and j: gain fix and azimuth fold
  logic signed [HW-1:0]    ph_q;
  logic signed [ROT_W-1:0] sai_q, saj_q, hx, cb_d, cb_q;
  logic signed [ANG_W-1:0] bi_q, bj_d, bj_q;
  logic                    oi_q, oj_q, vi_q, vj_q;

  assign hx = ROT_W'(ph_q >>> 30);

  always_comb begin
    if (bi_q > HALF_PI) begin
      bj_d = bi_q - PI_ANG;
      cb_d = -hx;
    end else if (bi_q < -HALF_PI) begin
      bj_d = bi_q + PI_ANG;
      cb_d = -hx;
    end else begin
      bj_d = bi_q;
      cb_d = hx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= 1'b0;
      vj_q <= 1'b0;
    end else begin
      vi_q <= v2;
      vj_q <= vi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q  <= HW'(ca2) * HW'(INV_GAIN);
    sai_q <= sa2;
    bi_q  <= sd2[ANG_W:1];
    oi_q  <= sd2[0];
    saj_q <= sai_q;
    cb_q  <= cb_d;
    bj_q  <= bj_d;
    oj_q  <= oi_q;
  end

  // rotation row by the azimuth
  logic                    v3;
  logic signed [ROT_W-1:0] cb3, sb3;
  logic signed [ANG_W-1:0] res3;
  logic [ROT_W:0]          sd3;

  fray_chain #(.N(N), .W(ROT_W), .SW(ROT_W + 1), .VEC(1'b0)) u_rot2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vj_q),
    .a_i    (cb_q),
    .b_i    ('0),
    .ang_i  (bj_q),
    .side_i ({saj_q, oj_q}),
    .valid_o(v3),
    .a_o    (cb3),
    .b_o    (sb3),
    .ang_o  (res3),
    .side_o (sd3)
  );

  // stage k: round and output
  logic signed [ROT_W-1:0] sa3;
  ray_res_t                res_d;

  assign sa3 = sd3[ROT_W:1];

  always_comb begin
    if (sd3[0]) begin
      res_d.dir_x = '0;
      res_d.dir_y = '0;
      res_d.dir_z = '0;
    end else begin
      res_d.dir_x = to_q14((ROT_W+1)'(cb3));
      res_d.dir_y = to_q14((ROT_W+1)'(sb3));
      res_d.dir_z = to_q14(-((ROT_W+1)'(sa3)));
    end
    res_d.outside_circle = sd3[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

  // residual angles of the rotation rows and the residual of the vectoring row are not needed
  logic unused_ang;
  assign unused_ang = ^{res2, res3, rest1};

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.outside_circle |->
      res_o.dir_x == '0 && res_o.dir_y == '0 && res_o.dir_z == '0)
    else $error("outside transaction with nonzero direction");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start, LAT))
    else $error("result without matching start");

  a_cfg_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && wr_idx == REG_FIELD |=> field_q == $past(pwdata[14:0]))
    else $error("field_angle write lost");

endmodule

`default_nettype wire
